FILE: src/button_gesture_classifier_defines.svh
// ----------------------------------------------------------------------------
// button gesture classifier assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// checked only outside reset
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define BGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// types and constants shared by the button gesture classifier
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned BGC_IN_BUTTONS = 4;
  localparam int unsigned BGC_PORT_TIME_W = 32;
  localparam int unsigned BGC_MS_W = 16;
  localparam int unsigned BGC_APB_ADDR_W = 5;
  localparam int unsigned BGC_APB_DATA_W = 32;
  localparam int unsigned BGC_REG_IDX_W = 3;
  localparam int unsigned BGC_IN_DATA_W = 40;
  localparam int unsigned BGC_OUT_DATA_W = 16;

  localparam logic [BGC_MS_W-1:0] BGC_LONG_PRESS_RST = 16'd2000;
  localparam logic [BGC_MS_W-1:0] BGC_DBL_WINDOW_RST = 16'd400;

  typedef enum logic [BGC_REG_IDX_W-1:0] {
    REG_LONG_PRESS = 3'd0,
    REG_DBL_WINDOW = 3'd1,
    REG_CLICK_EN   = 3'd2,
    REG_LONG_EN    = 3'd3,
    REG_DBL_EN     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [BGC_MS_W-1:0]       long_ms;
    logic [BGC_MS_W-1:0]       window_ms;
    logic [BGC_IN_BUTTONS-1:0] click_en;
    logic [BGC_IN_BUTTONS-1:0] long_en;
    logic [BGC_IN_BUTTONS-1:0] dbl_en;
  } cfg_t;

  typedef struct packed {
    logic [BGC_MS_W-1:0] long_ms;
    logic [BGC_MS_W-1:0] window_ms;
    logic                click_en;
    logic                long_en;
    logic                dbl_en;
  } lane_cfg_t;

  typedef struct packed {
    logic click;
    logic long_press;
    logic dbl;
  } lane_evt_t;

endpackage

FILE: src/bgc_regs.sv
// ----------------------------------------------------------------------------
// bgc_regs
// apb register file holding thresholds and per-button enable masks
// ----------------------------------------------------------------------------
module bgc_regs
  import bgc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [BGC_APB_ADDR_W-1:0] paddr,
  input  logic [BGC_APB_DATA_W-1:0] pwdata,
  output logic [BGC_APB_DATA_W-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t                     cfg_q, cfg_d;
  logic [BGC_REG_IDX_W-1:0] idx;
  logic                     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[BGC_APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LONG_PRESS: cfg_d.long_ms   = pwdata[BGC_MS_W-1:0];
        REG_DBL_WINDOW: cfg_d.window_ms = pwdata[BGC_MS_W-1:0];
        REG_CLICK_EN:   cfg_d.click_en  = pwdata[BGC_IN_BUTTONS-1:0];
        REG_LONG_EN:    cfg_d.long_en   = pwdata[BGC_IN_BUTTONS-1:0];
        REG_DBL_EN:     cfg_d.dbl_en    = pwdata[BGC_IN_BUTTONS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LONG_PRESS: prdata = BGC_APB_DATA_W'(cfg_q.long_ms);
      REG_DBL_WINDOW: prdata = BGC_APB_DATA_W'(cfg_q.window_ms);
      REG_CLICK_EN:   prdata = BGC_APB_DATA_W'(cfg_q.click_en);
      REG_LONG_EN:    prdata = BGC_APB_DATA_W'(cfg_q.long_en);
      REG_DBL_EN:     prdata = BGC_APB_DATA_W'(cfg_q.dbl_en);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ms   <= BGC_LONG_PRESS_RST;
      cfg_q.window_ms <= BGC_DBL_WINDOW_RST;
      cfg_q.click_en  <= '0;
      cfg_q.long_en   <= '0;
      cfg_q.dbl_en    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/bgc_lane.sv
// ----------------------------------------------------------------------------
// bgc_lane
// per-button gesture state and event decision for one poll
// ----------------------------------------------------------------------------
module bgc_lane
  import bgc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 pressed_i,
  input  logic                 mark_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  lane_cfg_t            cfg_i,
  output lane_evt_t            evt_o
);

  logic                 held_q, held_d;
  logic                 cons_q, cons_d;
  logic                 pend_q, pend_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic [TIME_BITS-1:0] rel_q, rel_d;
  logic                 cons_m;
  logic [TIME_BITS-1:0] el_press, el_rel;
  logic                 long_hit, in_win;

  assign cons_m   = cons_q | mark_i;
  // wrapping differences
  assign el_press = now_i - press_q;
  assign el_rel   = now_i - rel_q;
  assign long_hit = el_press > TIME_BITS'(cfg_i.long_ms);
  assign in_win   = el_rel < TIME_BITS'(cfg_i.window_ms);

  always_comb begin
    held_d = held_q;
    cons_d = cons_m;
    pend_d = pend_q;
    press_d = press_q;
    rel_d  = rel_q;
    evt_o  = '0;
    if (pressed_i) begin
      if (!held_q) begin
        held_d  = 1'b1;
        press_d = now_i;
        cons_d  = 1'b0;
      end else if (!cons_m && long_hit) begin
        evt_o.long_press = cfg_i.long_en;
        cons_d = 1'b1;
      end
    end else if (held_q) begin
      if (!cons_m) begin
        if (cfg_i.dbl_en) begin
          if (pend_q && in_win) begin
            evt_o.dbl = 1'b1;
            pend_d = 1'b0;
          end else begin
            pend_d = 1'b1;
            rel_d  = now_i;
          end
        end else begin
          evt_o.click = cfg_i.click_en;
        end
      end
      held_d = 1'b0;
      cons_d = 1'b0;
    end else if (cfg_i.dbl_en && pend_q && !in_win) begin
      evt_o.click = cfg_i.click_en;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      cons_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (advance_i) begin
      held_q <= held_d;
      cons_q <= cons_d;
      pend_q <= pend_d;
    end
  end

  // press and release timestamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      rel_q   <= '0;
    end else if (advance_i) begin
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

endmodule

FILE: src/bgc_merge.sv
// ----------------------------------------------------------------------------
// bgc_merge
// gathers lane events into masks and buffers results in an output stage
// ----------------------------------------------------------------------------
module bgc_merge
  import bgc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lane_evt_t [NUM_BUTTONS-1:0] evt_i,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [BGC_OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned EvtW = 3 * BGC_IN_BUTTONS;

  logic [BGC_IN_BUTTONS-1:0] clicks, longs, dbls;
  logic [EvtW-1:0]           res;
  logic [EvtW-1:0]           out_q, out_d, skid_q, skid_d;
  logic                      out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic                      accept, take;

  for (genvar i = 0; i < BGC_IN_BUTTONS; i++) begin : g_bit
    if (i < NUM_BUTTONS) begin : g_lane
      assign clicks[i] = evt_i[i].click;
      assign longs[i]  = evt_i[i].long_press;
      assign dbls[i]   = evt_i[i].dbl;
    end else begin : g_none
      assign clicks[i] = 1'b0;
      assign longs[i]  = 1'b0;
      assign dbls[i]   = 1'b0;
    end
  end

  assign res        = {dbls, longs, clicks};
  assign in_ready_o = !skid_vld_q;
  assign accept     = in_valid_i & in_ready_o;
  assign take       = out_vld_q & m_tready;
  assign m_tvalid   = out_vld_q;
  assign m_tdata    = BGC_OUT_DATA_W'(out_q);

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = accept;
      end
    end else if (accept) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

FILE: src/button_gesture_classifier.sv
// an accepted poll's masks are registered in the output register, or the skid register
// throughput: one poll per cycle unless the skid register is full
// a two-entry output stage keeps s_tready high while one result waits downstream
// reset (rst_ni low, asynchronous): button state and output stage cleared,
// thresholds back to 2000 ms and 400 ms, all enable masks off
// ----------------------------------------------------------------------------
// button_gesture_classifier
// click, long press and double click detection on active-low buttons
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // poll request channel
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // levels [3:0], now_ms [35:4], mark_handled [39:36]
  input  logic [BGC_IN_DATA_W-1:0]  s_tdata,
  // event result channel
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // click_events [3:0], long_events [7:4], double_events [11:8], zero [15:12]
  output logic [BGC_OUT_DATA_W-1:0] m_tdata,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [BGC_APB_ADDR_W-1:0] paddr,
  input  logic [BGC_APB_DATA_W-1:0] pwdata,
  output logic [BGC_APB_DATA_W-1:0] prdata,
  output logic                      pready
);

  // unpacked poll fields
  logic [BGC_IN_BUTTONS-1:0]  levels;
  logic [BGC_PORT_TIME_W-1:0] now_ms;
  logic [BGC_IN_BUTTONS-1:0]  mark_handled;
  logic                       advance;
  cfg_t                       cfg;
  lane_evt_t [NUM_BUTTONS-1:0] evt;

  assign levels       = s_tdata[BGC_IN_BUTTONS-1:0];
  assign now_ms       = s_tdata[BGC_PORT_TIME_W+BGC_IN_BUTTONS-1:BGC_IN_BUTTONS];
  assign mark_handled = s_tdata[BGC_IN_DATA_W-1:BGC_PORT_TIME_W+BGC_IN_BUTTONS];

  // lane state moves only on an accepted poll request
  assign advance = s_tvalid & s_tready;

  bgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one lane per button, all evaluated in the same cycle
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic      pressed;
    logic      mark;
    lane_cfg_t lcfg;

    if (i < BGC_IN_BUTTONS) begin : g_pin
      assign pressed      = !levels[i];
      assign mark         = mark_handled[i];
      assign lcfg.click_en = cfg.click_en[i];
      assign lcfg.long_en  = cfg.long_en[i];
      assign lcfg.dbl_en   = cfg.dbl_en[i];
    end else begin : g_nopin
      // no pin bit: reads as pressed, nothing enabled
      assign pressed      = 1'b1;
      assign mark         = 1'b0;
      assign lcfg.click_en = 1'b0;
      assign lcfg.long_en  = 1'b0;
      assign lcfg.dbl_en   = 1'b0;
    end
    assign lcfg.long_ms   = cfg.long_ms;
    assign lcfg.window_ms = cfg.window_ms;

    bgc_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .pressed_i (pressed),
      .mark_i    (mark),
      .now_i     (now_ms[TIME_BITS-1:0]),
      .cfg_i     (lcfg),
      .evt_o     (evt[i])
    );
  end

  // merge lane events into masks and buffer them towards the master side
  bgc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .evt_i      (evt),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: src/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker
// port-level checks on the result channel of the gesture classifier
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_defines.svh"

module bgc_checker
  import bgc_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [BGC_OUT_DATA_W-1:0] m_tdata
);

  `BGC_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_tvalid, "result valid during reset")
  `BGC_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
  `BGC_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[15:12] == 4'd0, "result padding not zero")
  `BGC_ASSERT(a_empty_fill, s_tvalid && s_tready && !m_tvalid |=> m_tvalid, "accepted poll lost")
  `BGC_ASSERT(a_no_invent, $rose(m_tvalid) |-> $past(s_tvalid && s_tready), "result without poll")

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

FILE: tb/gesture_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// gesture scoreboard
// per-button gesture prediction and in-order checking of event masks
// ----------------------------------------------------------------------------
package gesture_scoreboard_pkg;

  import bgc_pkg::*;

  localparam int unsigned NUM_LANES = BGC_IN_BUTTONS;

  typedef struct packed {
    logic [NUM_LANES-1:0] clicks;
    logic [NUM_LANES-1:0] longs;
    logic [NUM_LANES-1:0] doubles;
  } gesture_masks_t;

  class gesture_scoreboard;

    // register copies
    bit [BGC_MS_W-1:0]  long_ms;
    bit [BGC_MS_W-1:0]  window_ms;
    bit [NUM_LANES-1:0] click_en;
    bit [NUM_LANES-1:0] long_en;
    bit [NUM_LANES-1:0] dbl_en;

    // per-button tracking
    bit                       is_down[NUM_LANES];
    bit                       handled[NUM_LANES];
    bit                       click_waiting[NUM_LANES];
    bit [BGC_PORT_TIME_W-1:0] down_at[NUM_LANES];
    bit [BGC_PORT_TIME_W-1:0] up_at[NUM_LANES];

    gesture_masks_t awaited[$];
    int             errors;

    function new();
      long_ms   = BGC_LONG_PRESS_RST;
      window_ms = BGC_DBL_WINDOW_RST;
      click_en  = '0;
      long_en   = '0;
      dbl_en    = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        is_down[i]       = 1'b0;
        handled[i]       = 1'b0;
        click_waiting[i] = 1'b0;
        down_at[i]       = '0;
        up_at[i]         = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [BGC_APB_DATA_W-1:0] value);
      case (idx)
        REG_LONG_PRESS: long_ms   = value[BGC_MS_W-1:0];
        REG_DBL_WINDOW: window_ms = value[BGC_MS_W-1:0];
        REG_CLICK_EN:   click_en  = value[NUM_LANES-1:0];
        REG_LONG_EN:    long_en   = value[NUM_LANES-1:0];
        REG_DBL_EN:     dbl_en    = value[NUM_LANES-1:0];
        default: ;
      endcase
    endfunction

    // one accepted poll request: advance every button and queue its masks
    function void note_poll(bit [BGC_IN_DATA_W-1:0] data);
      bit [NUM_LANES-1:0]       levels;
      bit [BGC_PORT_TIME_W-1:0] now;
      bit [NUM_LANES-1:0]       mark;
      bit [BGC_PORT_TIME_W-1:0] held_for;
      bit [BGC_PORT_TIME_W-1:0] since_up;
      gesture_masks_t           res;
      levels = data[NUM_LANES-1:0];
      now    = data[NUM_LANES +: BGC_PORT_TIME_W];
      mark   = data[NUM_LANES+BGC_PORT_TIME_W +: NUM_LANES];
      res    = '0;

      // handled mask goes in before any button is looked at
      for (int i = 0; i < NUM_LANES; i++)
        if (mark[i]) handled[i] = 1'b1;

      for (int i = 0; i < NUM_LANES; i++) begin
        held_for = now - down_at[i];
        since_up = now - up_at[i];
        if (!levels[i]) begin
          if (!is_down[i]) begin
            is_down[i] = 1'b1;
            down_at[i] = now;
            handled[i] = 1'b0;
          end else if (!handled[i] && held_for > {16'd0, long_ms}) begin
            if (long_en[i]) res.longs[i] = 1'b1;
            handled[i] = 1'b1;
          end
        end else if (is_down[i]) begin
          if (!handled[i]) begin
            if (dbl_en[i]) begin
              if (click_waiting[i] && since_up < {16'd0, window_ms}) begin
                res.doubles[i]   = 1'b1;
                click_waiting[i] = 1'b0;
              end else begin
                click_waiting[i] = 1'b1;
                up_at[i]         = now;
              end
            end else if (click_en[i]) begin
              res.clicks[i] = 1'b1;
            end
          end
          is_down[i] = 1'b0;
          handled[i] = 1'b0;
        end else if (dbl_en[i] && click_waiting[i] && since_up >= {16'd0, window_ms}) begin
          if (click_en[i]) res.clicks[i] = 1'b1;
          click_waiting[i] = 1'b0;
        end
      end
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, bit [NUM_LANES-1:0] exp, bit [NUM_LANES-1:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %h, got %h", name, exp, act);
        errors++;
      end
    endfunction

    // one accepted event request from the block
    function void check_result(logic [BGC_OUT_DATA_W-1:0] data);
      gesture_masks_t exp;
      if (awaited.size() == 0) begin
        $error("event request %h arrived with nothing expected", data);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      compare_field("click_events", exp.clicks, data[3:0]);
      compare_field("long_events", exp.longs, data[7:4]);
      compare_field("double_events", exp.doubles, data[11:8]);
      compare_field("padding", 4'h0, data[15:12]);
    endfunction

  endclass

endpackage

FILE: tb/button_gesture_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// drives button polls with random idling on both stream sides, predicts the
// click, long press and double click masks and checks every event request
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bgc_pkg::*;
  import gesture_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned BURST_ITEMS   = 60;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // levels [3:0], now_ms [35:4], mark_handled [39:36]
  logic [BGC_IN_DATA_W-1:0]  s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // click_events [3:0], long_events [7:4], double_events [11:8], zero [15:12]
  logic [BGC_OUT_DATA_W-1:0] m_tdata;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [BGC_APB_ADDR_W-1:0] paddr    = '0;
  logic [BGC_APB_DATA_W-1:0] pwdata   = '0;
  logic [BGC_APB_DATA_W-1:0] prdata;
  logic                      pready;

  gesture_scoreboard sb;

  // idling in percent per cycle, changed between phases
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 47;

  // running stimulus state: button levels and the millisecond clock
  bit [3:0]  lvl_state = 4'hF;
  bit [31:0] clock_ms  = '0;

  int unsigned cycles = 0;

  button_gesture_classifier DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side stalls at random
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitors: values seen here are the ones settled before the edge
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) sb.note_poll(s_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // offer one poll request, with random idle cycles in front
  task automatic send_poll(input bit [3:0] lv, input bit [31:0] now, input bit [3:0] mk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mk, now, lv};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // hold the sender until every expected event request is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input reg_idx_e idx, input bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers change only once the block has gone quiet
  task automatic apply_setting(input bit [31:0] lp, input bit [31:0] win,
                               input bit [31:0] ce, input bit [31:0] le,
                               input bit [31:0] de);
    wait_drained();
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_DBL_WINDOW, win);
    write_reg(REG_CLICK_EN, ce);
    write_reg(REG_LONG_EN, le);
    write_reg(REG_DBL_EN, de);
  endtask

  // mostly plausible gesture sequences on a running clock, some noise
  task automatic run_random(input int count);
    bit [31:0] step;
    bit [3:0]  mk;
    clock_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      // one pause per burst until the pipe is empty
      if (n == count / 2) wait_drained();
      if ($urandom_range(0, 99) < 10) begin
        // noise: any levels, any time, any mark
        lvl_state = 4'($urandom);
        clock_ms  = $urandom;
        mk        = 4'($urandom);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: step = $urandom_range(0, 3);
          3, 4:    step = $urandom_range(0, sb.window_ms * 2 + 2);
          5:       step = sb.window_ms + $urandom_range(0, 2) - 1;  // window edge
          6, 7:    step = $urandom_range(0, sb.long_ms + sb.long_ms / 4 + 2);
          8:       step = sb.long_ms + $urandom_range(0, 2) - 1;    // threshold edge
          default: step = $urandom;                                 // wide jump
        endcase
        clock_ms = clock_ms + step;
        for (int i = 0; i < 4; i++)
          if ($urandom_range(0, 99) < 30) lvl_state[i] = ~lvl_state[i];
        mk = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0;
      end
      send_poll(lvl_state, clock_ms, mk);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short thresholds so the directed gestures stay readable;
    // buttons 0 and 2 wait for a second click, 1 and 3 report at once
    apply_setting(10, 5, 4'hF, 4'hF, 4'b0101);

    send_poll(4'hF, 32'd0, 4'h0);          // all released, time zero
    send_poll(4'h0, 32'd100, 4'hF);        // press edges: the mark is lost
    send_poll(4'hF, 32'd103, 4'h0);        // 1 and 3 click, 0 and 2 pending
    send_poll(4'hE, 32'd105, 4'h0);
    send_poll(4'hF, 32'd106, 4'h0);        // button 0 double click
    send_poll(4'hF, 32'd108, 4'h0);        // button 2 window closed: click
    send_poll(4'hB, 32'd110, 4'h0);
    send_poll(4'hF, 32'd111, 4'h0);        // button 2 pending again
    send_poll(4'hB, 32'd120, 4'h0);
    send_poll(4'hF, 32'd121, 4'h0);        // late second click restarts window
    send_poll(4'hF, 32'd126, 4'h0);        // ...then a single click
    send_poll(4'hD, 32'd200, 4'h0);        // button 1 held
    send_poll(4'hD, 32'd210, 4'h0);        // exactly at threshold: nothing
    send_poll(4'hD, 32'd211, 4'h0);        // long press
    send_poll(4'hD, 32'd300, 4'h0);        // fires only once
    send_poll(4'hF, 32'd301, 4'h0);        // handled release: no click
    send_poll(4'h7, 32'd400, 4'h0);
    send_poll(4'h7, 32'd401, 4'h8);        // mark while held
    send_poll(4'hF, 32'd402, 4'h0);        // so no click on release
    send_poll(4'hE, 32'hFFFF_FFFE, 4'h0);  // held across the wrap of time
    send_poll(4'hE, 32'h0000_0008, 4'h0);
    send_poll(4'hE, 32'h0000_0009, 4'h0);  // wrapped long press
    send_poll(4'hF, 32'hFFFF_FFFF, 4'hF);
    send_poll(4'h0, 32'd5, 4'h0);
    send_poll(4'hF, 32'd6, 4'h0);

    // phase one: sender idles lightly, receiver heavily
    run_random(BURST_ITEMS);
    apply_setting(0, 0, 4'hF, 4'hF, 4'hF);
    run_random(BURST_ITEMS);
    apply_setting(65535, 65535, 4'h5, 4'h3, 4'hF);
    run_random(BURST_ITEMS);

    // phase two: the other way round
    wait_drained();
    send_idle_pct = 47;
    recv_idle_pct = 14;
    apply_setting(20, 8, $urandom, $urandom, $urandom);
    run_random(BURST_ITEMS);
    apply_setting(1, 65535, 4'hF, 4'h0, 4'h3);
    run_random(BURST_ITEMS);
    apply_setting(65535, 1, 4'h0, 4'hF, 4'hC);
    run_random(BURST_ITEMS);

    // phase three: no idling at all
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting($urandom_range(0, 64), $urandom_range(0, 32), $urandom, $urandom, $urandom);
    run_random(BURST_ITEMS);
    apply_setting(40, 15, 4'hF, 4'hF, 4'hF);
    run_random(BURST_ITEMS);
    apply_setting(8, 4, 4'hF, 4'hF, 4'h0);
    run_random(BURST_ITEMS);

    // drain and let any stray request show up
    wait_drained();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
